>>> rtl/g2e_pkg.sv
// Shared constants, fixed-point helpers and reciprocal table for the
// geodetic to ECEF converter. No dependencies.
package g2e_pkg;

    localparam int ANGLE_BITS  = 32;
    localparam int LENGTH_BITS = 35;
    localparam int HEIGHT_BITS = 28;
    localparam int A_BITS      = 33;
    localparam int E2_BITS     = 29;
    localparam int OUT_BITS    = 34;

    // pipeline latencies of the three sections
    localparam int SIN_LAT   = 39;
    localparam int RAD_LAT   = 45;
    localparam int PRJ_LAT   = 6;
    localparam int TOTAL_LAT = SIN_LAT + RAD_LAT + PRJ_LAT;

    localparam logic [0:0] CFG_SEMI_MAJOR   = 1'b0;
    localparam logic [0:0] CFG_ECC_SQUARED  = 1'b1;
    localparam logic [A_BITS-1:0]  SEMI_MAJOR_RESET = 33'd6378137000;
    localparam logic [E2_BITS-1:0] ECC_RESET        = 29'd28752143;

    localparam logic [63:0] Q_ONE        = 64'h1000_0000_0000_0000;
    localparam logic [63:0] Q_THREE      = 64'h3000_0000_0000_0000;
    localparam logic [63:0] Q_QUARTER    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q_PI_HALF    = 64'h1921_FB54_442D_1847;
    localparam logic [63:0] INT64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // Horner divisors k(k+1) for k = 16 down to 2, as exact reciprocals:
    // quotient = (n * M) >> S for every n below 2^62
    localparam logic [127:0] P1 = 128'd1;
    localparam int DIV_S [8] = '{71, 70, 70, 69, 69, 68, 67, 65};
    localparam logic [63:0] DIV_M [8] = '{
        64'(((P1 << 71) + 128'd271) / 128'd272),
        64'(((P1 << 70) + 128'd209) / 128'd210),
        64'(((P1 << 70) + 128'd155) / 128'd156),
        64'(((P1 << 69) + 128'd109) / 128'd110),
        64'(((P1 << 69) + 128'd71) / 128'd72),
        64'(((P1 << 68) + 128'd41) / 128'd42),
        64'(((P1 << 67) + 128'd19) / 128'd20),
        64'(((P1 << 65) + 128'd5) / 128'd6)
    };

    // product scaled down by sh bits, round half up, low 64 bits kept
    function automatic logic [63:0] rshr(input logic [127:0] prod, input int unsigned sh);
        logic [127:0] sum;
        sum = prod + (P1 << (sh - 1));
        return 64'(sum >> sh);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // clamp a magnitude to the signed range and apply the sign
    function automatic logic signed [63:0] sfinish(input logic [63:0] mag, input logic neg);
        logic [63:0] c;
        c = (mag > INT64_MAX) ? INT64_MAX : mag;
        return neg ? -$signed(c) : $signed(c);
    endfunction

    function automatic logic signed [63:0] sat_len(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< (LENGTH_BITS - 1 + 12);
        if (v < -lim) return -lim;
        if (v > lim - 64'sd1) return lim - 64'sd1;
        return v;
    endfunction

    function automatic logic [OUT_BITS-1:0] pack_out(input logic signed [63:0] v);
        logic signed [63:0] lim;
        logic signed [63:0] c;
        lim = 64'sd1 <<< (OUT_BITS - 1);
        c = v;
        if (v < -lim) c = -lim;
        if (v > lim - 64'sd1) c = lim - 64'sd1;
        return c[OUT_BITS-1:0];
    endfunction

endpackage

>>> rtl/g2e_mul.sv
// Two-stage 64x64 unsigned multiplier: four 32x32 partial products, then
// their sum. Full 128-bit product. No dependencies.
module g2e_mul (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            p01_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            p10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg   <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                     + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/g2e_sin.sv
// Pipelined sine of a binary angle, signed Q.60 out: quadrant fold, Taylor
// series in Horner form with exact reciprocal division. Uses g2e_pkg, g2e_mul.
module g2e_sin (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [g2e_pkg::ANGLE_BITS-1:0]  angle,
    output logic signed [63:0]              sin_val
);
    import g2e_pkg::*;

    localparam int STEPS     = 8;
    localparam int X_DEPTH   = 34;
    localparam int X2_DEPTH  = 28;
    localparam int NEG_DEPTH = 38;

    logic [1:0]   quad;
    logic [63:0]  r_frac, x_val, x2_val, s_mag, s_clip;
    logic [127:0] p_x, p_xx, p_fin;
    logic [63:0]  x_line_reg  [X_DEPTH];
    logic [63:0]  x2_line_reg [X2_DEPTH];
    logic         neg_line_reg [NEG_DEPTH];
    logic signed [63:0] sin_reg;
    logic [63:0]  t_val   [STEPS+1];
    logic [63:0]  x2_step [STEPS];
    logic [127:0] pa [STEPS];
    logic [127:0] pb [STEPS];

    always_comb begin
        quad   = angle[ANGLE_BITS-1 -: 2];
        r_frac = 64'(angle[ANGLE_BITS-3:0]) << (64 - ANGLE_BITS);
        // mirror in odd quadrants
        if (quad[0]) begin
            r_frac = Q_QUARTER - r_frac;
        end
    end

    g2e_mul u_mul_x  (.aclk(aclk), .en(en), .a(r_frac), .b(Q_PI_HALF), .p(p_x));
    assign x_val = rshr(p_x, 62);
    g2e_mul u_mul_xx (.aclk(aclk), .en(en), .a(x_val), .b(x_val), .p(p_xx));
    assign x2_val = rshr(p_xx, 60);

    assign t_val[0] = Q_ONE;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [63:0] n_val;
        if (j == 0) begin : g_first
            assign x2_step[j] = x2_val;
        end else begin : g_rest
            assign x2_step[j] = x2_line_reg[4*j-1];
        end
        g2e_mul u_mul_a (.aclk(aclk), .en(en), .a(x2_step[j]), .b(t_val[j]), .p(pa[j]));
        assign n_val = rshr(pa[j], 60);
        g2e_mul u_mul_b (.aclk(aclk), .en(en), .a(n_val), .b(DIV_M[j]), .p(pb[j]));
        assign t_val[j+1] = Q_ONE - 64'(pb[j] >> DIV_S[j]);
    end

    g2e_mul u_mul_fin (.aclk(aclk), .en(en), .a(x_line_reg[X_DEPTH-1]), .b(t_val[STEPS]),
                       .p(p_fin));

    always_comb begin
        s_mag  = rshr(p_fin, 60);
        s_clip = (s_mag > Q_ONE) ? Q_ONE : s_mag;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_line_reg[0]   <= x_val;
            x2_line_reg[0]  <= x2_val;
            neg_line_reg[0] <= quad[1];
            for (int i = 1; i < X_DEPTH; i++) begin
                x_line_reg[i] <= x_line_reg[i-1];
            end
            for (int i = 1; i < X2_DEPTH; i++) begin
                x2_line_reg[i] <= x2_line_reg[i-1];
            end
            for (int i = 1; i < NEG_DEPTH; i++) begin
                neg_line_reg[i] <= neg_line_reg[i-1];
            end
            // negate in the lower half turn
            sin_reg <= neg_line_reg[NEG_DEPTH-1] ? -$signed(s_clip) : $signed(s_clip);
        end
    end

    assign sin_val = sin_reg;

endmodule

>>> rtl/g2e_radius.sv
// Prime-vertical radius by Newton inverse square root, then the horizontal
// and polar radii plus height, Q.12 mm. Uses g2e_pkg, g2e_mul.
module g2e_radius (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [63:0]                    slat,
    input  logic signed [g2e_pkg::HEIGHT_BITS-1:0] height,
    input  logic [g2e_pkg::A_BITS-1:0]            semi_major,
    input  logic [g2e_pkg::E2_BITS-1:0]           ecc_sq,
    output logic signed [63:0]                    rxy,
    output logic signed [63:0]                    rz
);
    import g2e_pkg::*;

    localparam int NEWTON  = 6;
    localparam int W_DEPTH = 32;
    localparam int H_DEPTH = 44;

    logic [63:0]  e2, sa, s2, w_val;
    logic [127:0] p_s2, p_w, p_n, p_z;
    logic [63:0]  w_line_reg [W_DEPTH];
    logic signed [HEIGHT_BITS-1:0] h_line_reg [H_DEPTH];
    logic [63:0]  y_val [NEWTON+1];
    logic signed [63:0] n12, h_a, h_b, rxy_sat, rz_sat;
    logic signed [63:0] rxy_line_reg [3];
    logic signed [63:0] rz_reg;

    assign e2 = 64'(ecc_sq) << 28;
    assign sa = abs64(slat);

    g2e_mul u_mul_s2 (.aclk(aclk), .en(en), .a(sa), .b(sa), .p(p_s2));
    assign s2 = rshr(p_s2, 60);
    g2e_mul u_mul_w (.aclk(aclk), .en(en), .a(e2), .b(s2), .p(p_w));
    assign w_val = Q_ONE - rshr(p_w, 60);

    assign y_val[0] = Q_ONE;

    // y <- y (3 - w y^2) / 2, six steps
    for (genvar j = 0; j < NEWTON; j++) begin : g_newton
        logic [127:0] pa, pb, pc;
        logic [63:0]  yy, wy2;
        logic [63:0]  y_dl_reg [4];
        g2e_mul u_mul_a (.aclk(aclk), .en(en), .a(y_val[j]), .b(y_val[j]), .p(pa));
        assign yy = rshr(pa, 60);
        g2e_mul u_mul_b (.aclk(aclk), .en(en), .a(w_line_reg[6*j+1]), .b(yy), .p(pb));
        assign wy2 = rshr(pb, 60);
        g2e_mul u_mul_c (.aclk(aclk), .en(en), .a(y_dl_reg[3]), .b(Q_THREE - wy2), .p(pc));
        assign y_val[j+1] = rshr(pc, 61);
        always_ff @(posedge aclk) begin
            if (en) begin
                y_dl_reg[0] <= y_val[j];
                for (int i = 1; i < 4; i++) begin
                    y_dl_reg[i] <= y_dl_reg[i-1];
                end
            end
        end
    end

    g2e_mul u_mul_n (.aclk(aclk), .en(en), .a(64'(semi_major)), .b(y_val[NEWTON]), .p(p_n));
    assign n12 = $signed(rshr(p_n, 48));
    g2e_mul u_mul_z (.aclk(aclk), .en(en), .a(n12), .b(Q_ONE - e2), .p(p_z));

    always_comb begin
        h_a     = {{(64-HEIGHT_BITS-12){h_line_reg[41][HEIGHT_BITS-1]}}, h_line_reg[41], 12'd0};
        h_b     = {{(64-HEIGHT_BITS-12){h_line_reg[43][HEIGHT_BITS-1]}}, h_line_reg[43], 12'd0};
        rxy_sat = sat_len(n12 + h_a);
        rz_sat  = sat_len($signed(rshr(p_z, 60)) + h_b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_line_reg[0] <= w_val;
            for (int i = 1; i < W_DEPTH; i++) begin
                w_line_reg[i] <= w_line_reg[i-1];
            end
            h_line_reg[0] <= height;
            for (int i = 1; i < H_DEPTH; i++) begin
                h_line_reg[i] <= h_line_reg[i-1];
            end
            // hold the horizontal radius while the polar product finishes
            rxy_line_reg[0] <= rxy_sat;
            rxy_line_reg[1] <= rxy_line_reg[0];
            rxy_line_reg[2] <= rxy_line_reg[1];
            rz_reg          <= rz_sat;
        end
    end

    assign rxy = rxy_line_reg[2];
    assign rz  = rz_reg;

endmodule

>>> rtl/g2e_project.sv
// Projection of the radii onto the axes with signed rounded products and
// saturation to the output width. Uses g2e_pkg, g2e_mul.
module g2e_project (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [63:0]                    rxy,
    input  logic signed [63:0]                    rz,
    input  logic signed [63:0]                    clat,
    input  logic signed [63:0]                    slat,
    input  logic signed [63:0]                    clon,
    input  logic signed [63:0]                    slon,
    output logic [g2e_pkg::OUT_BITS-1:0]          ecef_x,
    output logic [g2e_pkg::OUT_BITS-1:0]          ecef_y,
    output logic [g2e_pkg::OUT_BITS-1:0]          ecef_z
);
    import g2e_pkg::*;

    logic [127:0] pp, px, py, pz;
    logic         negp_reg [2];
    logic         negx_reg [2];
    logic         negy_reg [2];
    logic         negz_reg [2];
    logic signed [63:0] clon_reg [3];
    logic signed [63:0] slon_reg [3];
    logic signed [63:0] slat_reg [3];
    logic signed [63:0] rz_line_reg [3];
    logic signed [63:0] p_reg;
    logic [OUT_BITS-1:0] x_reg, y_reg, z_reg;

    g2e_mul u_mul_p (.aclk(aclk), .en(en), .a(abs64(rxy)), .b(abs64(clat)), .p(pp));
    g2e_mul u_mul_x (.aclk(aclk), .en(en), .a(abs64(p_reg)), .b(abs64(clon_reg[2])), .p(px));
    g2e_mul u_mul_y (.aclk(aclk), .en(en), .a(abs64(p_reg)), .b(abs64(slon_reg[2])), .p(py));
    g2e_mul u_mul_z (.aclk(aclk), .en(en), .a(abs64(rz_line_reg[2])), .b(abs64(slat_reg[2])),
                     .p(pz));

    always_ff @(posedge aclk) begin
        if (en) begin
            negp_reg[0] <= rxy[63] ^ clat[63];
            negp_reg[1] <= negp_reg[0];
            negx_reg[0] <= p_reg[63] ^ clon_reg[2][63];
            negx_reg[1] <= negx_reg[0];
            negy_reg[0] <= p_reg[63] ^ slon_reg[2][63];
            negy_reg[1] <= negy_reg[0];
            negz_reg[0] <= rz_line_reg[2][63] ^ slat_reg[2][63];
            negz_reg[1] <= negz_reg[0];
            clon_reg[0]    <= clon;
            slon_reg[0]    <= slon;
            slat_reg[0]    <= slat;
            rz_line_reg[0] <= rz;
            for (int i = 1; i < 3; i++) begin
                clon_reg[i]    <= clon_reg[i-1];
                slon_reg[i]    <= slon_reg[i-1];
                slat_reg[i]    <= slat_reg[i-1];
                rz_line_reg[i] <= rz_line_reg[i-1];
            end
            p_reg <= sfinish(rshr(pp, 60), negp_reg[1]);
            x_reg <= pack_out(sfinish(rshr(px, 72), negx_reg[1]));
            y_reg <= pack_out(sfinish(rshr(py, 72), negy_reg[1]));
            z_reg <= pack_out(sfinish(rshr(pz, 72), negz_reg[1]));
        end
    end

    assign ecef_x = x_reg;
    assign ecef_y = y_reg;
    assign ecef_z = z_reg;

endmodule

>>> rtl/geodetic_to_ecef_top.sv
// Geodetic to ECEF converter, top level: handshakes, ellipsoid registers,
// alignment delays. Uses g2e_pkg, g2e_sin, g2e_radius, g2e_project.
//
//  channel  direction  handshake              payload
//  s_       in         s_tvalid / s_tready    latitude, longitude, height_mm
//  m_       out        m_tvalid / m_tready    ecef_x_mm, ecef_y_mm, ecef_z_mm
//  cfg_     in         cfg_valid / cfg_ready  register index, data
//
// One item per cycle while the output is not stalled; the delay from input to output is set by
// the eight Horner steps of the sine and the six Newton steps of the radius,
// every 64x64 product split into four 32x32 partials over two stages.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// aresetn clears the valid bits and loads the WGS84 ellipsoid.
module geodetic_to_ecef_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // latitude[31:0], longitude[63:32], height_mm[91:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // ecef_x_mm[33:0], ecef_y_mm[67:34], ecef_z_mm[101:68]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [32:0]  cfg_data
);
    import g2e_pkg::*;

    logic                  en;
    logic [TOTAL_LAT-1:0]  valid_reg;
    logic [A_BITS-1:0]     semi_major_reg;
    logic [E2_BITS-1:0]    ecc_reg;
    logic [ANGLE_BITS-1:0] lat, lon;
    logic signed [HEIGHT_BITS-1:0] height;
    logic signed [HEIGHT_BITS-1:0] h_line_reg [SIN_LAT];
    logic signed [63:0] slat, clat, slon, clon, rxy, rz;
    logic signed [63:0] slat_line_reg [RAD_LAT];
    logic signed [63:0] clat_line_reg [RAD_LAT];
    logic signed [63:0] slon_line_reg [RAD_LAT];
    logic signed [63:0] clon_line_reg [RAD_LAT];
    logic [OUT_BITS-1:0] ecef_x, ecef_y, ecef_z;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign lat    = s_tdata[31:0];
    assign lon    = s_tdata[63:32];
    assign height = s_tdata[91:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            semi_major_reg <= SEMI_MAJOR_RESET;
            ecc_reg        <= ECC_RESET;
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[TOTAL_LAT-2:0], s_tvalid};
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SEMI_MAJOR:  semi_major_reg <= cfg_data[A_BITS-1:0];
                    CFG_ECC_SQUARED: ecc_reg        <= cfg_data[E2_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // cosine as the sine a quarter turn on
    g2e_sin u_sin_lat (.aclk(aclk), .en(en), .angle(lat), .sin_val(slat));
    g2e_sin u_cos_lat (.aclk(aclk), .en(en), .angle(lat + ANGLE_QUARTER), .sin_val(clat));
    g2e_sin u_sin_lon (.aclk(aclk), .en(en), .angle(lon), .sin_val(slon));
    g2e_sin u_cos_lon (.aclk(aclk), .en(en), .angle(lon + ANGLE_QUARTER), .sin_val(clon));

    always_ff @(posedge aclk) begin
        if (en) begin
            h_line_reg[0] <= height;
            for (int i = 1; i < SIN_LAT; i++) begin
                h_line_reg[i] <= h_line_reg[i-1];
            end
            slat_line_reg[0] <= slat;
            clat_line_reg[0] <= clat;
            slon_line_reg[0] <= slon;
            clon_line_reg[0] <= clon;
            for (int i = 1; i < RAD_LAT; i++) begin
                slat_line_reg[i] <= slat_line_reg[i-1];
                clat_line_reg[i] <= clat_line_reg[i-1];
                slon_line_reg[i] <= slon_line_reg[i-1];
                clon_line_reg[i] <= clon_line_reg[i-1];
            end
        end
    end

    g2e_radius u_radius (
        .aclk(aclk), .en(en), .slat(slat), .height(h_line_reg[SIN_LAT-1]),
        .semi_major(semi_major_reg), .ecc_sq(ecc_reg), .rxy(rxy), .rz(rz)
    );

    g2e_project u_project (
        .aclk(aclk), .en(en), .rxy(rxy), .rz(rz),
        .clat(clat_line_reg[RAD_LAT-1]), .slat(slat_line_reg[RAD_LAT-1]),
        .clon(clon_line_reg[RAD_LAT-1]), .slon(slon_line_reg[RAD_LAT-1]),
        .ecef_x(ecef_x), .ecef_y(ecef_y), .ecef_z(ecef_z)
    );

    assign m_tvalid = valid_reg[TOTAL_LAT-1];
    assign m_tdata  = {2'b00, ecef_z, ecef_y, ecef_x};

endmodule

>>> rtl/geodetic_to_ecef_checker.sv
// Port-level checks for the geodetic to ECEF converter, bound to the top
// level. No dependencies beyond the top level's ports.
module geodetic_to_ecef_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item shown straight after reset");

    // a stalled result stalls the input side too
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the output is stalled");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

endmodule

bind geodetic_to_ecef_top geodetic_to_ecef_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> test/tb_geodetic_to_ecef_top.sv
// Self-checking testbench for geodetic_to_ecef_top: drives random and edge
// positions, predicts ECEF results in fixed point and compares each item.
// Depends on g2e_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_geodetic_to_ecef_top;
    import g2e_pkg::*;

    typedef struct packed {
        logic [33:0] z;
        logic [33:0] y;
        logic [33:0] x;
    } ecef_t;

    typedef struct {
        logic [31:0] lat;
        logic [31:0] lon;
        logic [27:0] hgt;
    } position_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = '0;
    logic [32:0]  cfg_data = '0;

    geodetic_to_ecef_top u_dut (.*);

    logic [32:0] ell_a = SEMI_MAJOR_RESET;
    logic [28:0] ell_e2 = ECC_RESET;

    position_t pending_pos[$];
    ecef_t     expected_ecef[$];
    int        errors = 0;
    int        send_gap = 0;
    int        take_gap = 0;
    bit        hold_send = 1'b0;

    initial forever #5 aclk = ~aclk;

    // (a*b) >> s, round half up, low 64 bits kept
    function automatic logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        return 64'(p >> s);
    endfunction

    function automatic logic signed [63:0] smul_rnd(logic signed [63:0] a,
                                                     logic signed [63:0] b, int s);
        logic [63:0] ma, mb, r;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r = mul_rnd(ma, mb, s);
        if (r > 64'h7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] sine_q60(logic [31:0] ang);
        logic [1:0]  quad;
        logic [63:0] r, x, x2, t;
        quad = ang[31:30];
        r = {2'b00, ang[29:0], 32'd0};
        if (quad[0]) r = (64'd1 << 62) - r;
        x = mul_rnd(r, 64'h1921FB54442D1847, 62);
        x2 = mul_rnd(x, x, 60);
        t = 64'd1 << 60;
        for (int k = 16; k >= 2; k -= 2)
            t = (64'd1 << 60) - mul_rnd(x2, t, 60) / 64'(k * (k + 1));
        t = mul_rnd(x, t, 60);
        if (t > (64'd1 << 60)) t = 64'd1 << 60;
        return quad[1] ? -$signed(t) : $signed(t);
    endfunction

    function automatic logic signed [63:0] clamp_len(logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< 46;
        if (v < -lim) return -lim;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    function automatic logic [33:0] clamp_out(logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< 33;
        if (v < -lim) v = -lim;
        if (v > lim - 1) v = lim - 1;
        return v[33:0];
    endfunction

    function automatic ecef_t to_ecef(position_t p);
        logic signed [63:0] slat, clat, slon, clon, h, n12, rxy, rz, pr;
        logic [63:0] e2, sa, w, yv, wy2;
        ecef_t o;
        h = 64'($signed(p.hgt));
        slat = sine_q60(p.lat);
        clat = sine_q60(p.lat + 32'h4000_0000);
        slon = sine_q60(p.lon);
        clon = sine_q60(p.lon + 32'h4000_0000);
        e2 = 64'(ell_e2) << 28;
        sa = slat < 0 ? -slat : slat;
        w = (64'd1 << 60) - mul_rnd(e2, mul_rnd(sa, sa, 60), 60);
        yv = 64'd1 << 60;
        for (int i = 0; i < 6; i++) begin
            wy2 = mul_rnd(w, mul_rnd(yv, yv, 60), 60);
            yv = mul_rnd(yv, 64'h3000_0000_0000_0000 - wy2, 61);
        end
        n12 = mul_rnd(64'(ell_a), yv, 48);
        rxy = clamp_len(n12 + h * 4096);
        rz = clamp_len($signed(mul_rnd(n12, (64'd1 << 60) - e2, 60)) + h * 4096);
        pr = smul_rnd(rxy, clat, 60);
        o.x = clamp_out(smul_rnd(pr, clon, 72));
        o.y = clamp_out(smul_rnd(pr, slon, 72));
        o.z = clamp_out(smul_rnd(rz, slat, 72));
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sender: predict on acceptance, then load the next item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_ecef.push_back(to_ecef(pending_pos.pop_front()));
                send_gap <= pick_gap();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (!(s_tvalid && s_tready) && send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_pos.size() > 0
                             && !hold_send && !(s_tvalid && s_tready && send_gap != 0)) begin
                    automatic position_t nx = pending_pos[0];
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'd0, nx.hgt, nx.lon, nx.lat};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, compare each result item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_ecef.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    automatic ecef_t ex = expected_ecef.pop_front();
                    automatic ecef_t ac = m_tdata[101:0];
                    if (ac.x !== ex.x) begin
                        $error("ecef_x_mm expected %0d got %0d", $signed(ex.x), $signed(ac.x));
                        errors++;
                    end
                    if (ac.y !== ex.y) begin
                        $error("ecef_y_mm expected %0d got %0d", $signed(ex.y), $signed(ac.y));
                        errors++;
                    end
                    if (ac.z !== ex.z) begin
                        $error("ecef_z_mm expected %0d got %0d", $signed(ex.z), $signed(ac.z));
                        errors++;
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) take_gap <= pick_gap();
            end
        end
    end

    task automatic add_pos(logic [31:0] lat, logic [31:0] lon, logic [27:0] hgt);
        position_t p;
        p.lat = lat;
        p.lon = lon;
        p.hgt = hgt;
        pending_pos.push_back(p);
    endtask

    task automatic drain();
        wait (pending_pos.size() == 0);
        wait (expected_ecef.size() == 0);
        repeat (TOTAL_LAT + 10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [32:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SEMI_MAJOR) ell_a = val;
        else ell_e2 = val[28:0];
    endtask

    task automatic random_batch(int count);
        for (int i = 0; i < count; i++) begin
            int r;
            logic [31:0] lat;
            logic [27:0] h;
            r = $urandom_range(0, 9);
            lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            if (r == 0) lat = $urandom();
            h = 28'($urandom_range(0, 101000000) - 1000000);
            if (r == 1) h = 28'($urandom());
            add_pos(lat, $urandom(), h);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        add_pos(32'h0, 32'h0, 28'h0);
        add_pos(32'h4000_0000, 32'h0, 28'd100000000);
        add_pos(32'hC000_0000, 32'h8000_0000, -28'sd1000000);
        add_pos(32'h0, 32'h7FFF_FFFF, 28'h0);
        add_pos(32'h0, 32'h4000_0000, 28'h7FF_FFFF);
        add_pos(32'h0, 32'hC000_0000, 28'h800_0000);
        add_pos(32'h6000_0000, 32'h2000_0000, 28'd5000);
        add_pos(32'hA000_0000, 32'hFFFF_FFFF, 28'd1);
        add_pos(32'h3FFF_FFFF, 32'h0000_0001, 28'hFFF_FFFF);
        add_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF, 28'h0);
        add_pos(32'h8000_0000, 32'h1234_5678, 28'h555_5555);
        add_pos(32'hAAAA_AAAA, 32'h5555_5555, 28'hAAA_AAAA);
        random_batch(400);
        // stop feeding until the pipe is empty
        wait (pending_pos.size() == 0);
        hold_send = 1'b1;
        wait (expected_ecef.size() == 0);
        hold_send = 1'b0;
        random_batch(300);
        drain();

        write_reg(CFG_SEMI_MAJOR, 33'd7000000000);
        write_reg(CFG_ECC_SQUARED, 33'd429496729);
        random_batch(300);
        add_pos(32'h4000_0000, 32'h0, 28'd100000000);
        drain();
        write_reg(CFG_SEMI_MAJOR, 33'd6000000000);
        write_reg(CFG_ECC_SQUARED, 33'd0);
        random_batch(300);
        drain();
        write_reg(CFG_SEMI_MAJOR, 33'h1_FFFF_FFFF);
        write_reg(CFG_ECC_SQUARED, 33'h1_FFFF_FFFF);
        random_batch(100);
        drain();
        write_reg(CFG_SEMI_MAJOR, 33'd6378137000);
        write_reg(CFG_ECC_SQUARED, 33'd28752143);
        random_batch(250);
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
rtl/g2e_pkg.sv
rtl/g2e_mul.sv
rtl/g2e_sin.sv
rtl/g2e_radius.sv
rtl/g2e_project.sv
rtl/geodetic_to_ecef_top.sv
rtl/geodetic_to_ecef_checker.sv
test/tb_geodetic_to_ecef_top.sv
